// File: sv/csl_pkg.sv
// Package for the C subset lexer: token kinds, error codes, automaton states
// and the result word type. No dependencies.
package csl_pkg;

  localparam int KIND_W = 6;
  localparam int ERR_W  = 4;
  localparam int LINE_W = 24;
  localparam int VAL_W  = 31;
  localparam int REP_W  = 24;
  localparam int LEN_W  = 16;

  localparam logic [KIND_W-1:0] K_IDENT = 6'd0;
  localparam logic [KIND_W-1:0] K_BREAK = 6'd1;
  localparam logic [KIND_W-1:0] K_CHAR = 6'd2;
  localparam logic [KIND_W-1:0] K_DOUBLE = 6'd3;
  localparam logic [KIND_W-1:0] K_ELSE = 6'd4;
  localparam logic [KIND_W-1:0] K_FOR = 6'd5;
  localparam logic [KIND_W-1:0] K_IF = 6'd6;
  localparam logic [KIND_W-1:0] K_INT = 6'd7;
  localparam logic [KIND_W-1:0] K_RETURN = 6'd8;
  localparam logic [KIND_W-1:0] K_STRUCT = 6'd9;
  localparam logic [KIND_W-1:0] K_VOID = 6'd10;
  localparam logic [KIND_W-1:0] K_WHILE = 6'd11;
  localparam logic [KIND_W-1:0] K_CT_INT = 6'd12;
  localparam logic [KIND_W-1:0] K_CT_REAL = 6'd13;
  localparam logic [KIND_W-1:0] K_CT_CHAR = 6'd14;
  localparam logic [KIND_W-1:0] K_CT_STRING = 6'd15;
  localparam logic [KIND_W-1:0] K_COMMA = 6'd16;
  localparam logic [KIND_W-1:0] K_SEMI = 6'd17;
  localparam logic [KIND_W-1:0] K_LPAR = 6'd18;
  localparam logic [KIND_W-1:0] K_RPAR = 6'd19;
  localparam logic [KIND_W-1:0] K_LBRACK = 6'd20;
  localparam logic [KIND_W-1:0] K_RBRACK = 6'd21;
  localparam logic [KIND_W-1:0] K_LACC = 6'd22;
  localparam logic [KIND_W-1:0] K_RACC = 6'd23;
  localparam logic [KIND_W-1:0] K_END = 6'd24;
  localparam logic [KIND_W-1:0] K_ADD = 6'd25;
  localparam logic [KIND_W-1:0] K_SUB = 6'd26;
  localparam logic [KIND_W-1:0] K_MUL = 6'd27;
  localparam logic [KIND_W-1:0] K_DIV = 6'd28;
  localparam logic [KIND_W-1:0] K_DOT = 6'd29;
  localparam logic [KIND_W-1:0] K_AND = 6'd30;
  localparam logic [KIND_W-1:0] K_OR = 6'd31;
  localparam logic [KIND_W-1:0] K_NOT = 6'd32;
  localparam logic [KIND_W-1:0] K_ASSIGN = 6'd33;
  localparam logic [KIND_W-1:0] K_EQUAL = 6'd34;
  localparam logic [KIND_W-1:0] K_NOTEQ = 6'd35;
  localparam logic [KIND_W-1:0] K_LESS = 6'd36;
  localparam logic [KIND_W-1:0] K_LESSEQ = 6'd37;
  localparam logic [KIND_W-1:0] K_GREATER = 6'd38;
  localparam logic [KIND_W-1:0] K_GREATEREQ = 6'd39;

  localparam logic [ERR_W-1:0] E_NONE = 4'd0;
  localparam logic [ERR_W-1:0] E_BAD_CHAR = 4'd1;
  localparam logic [ERR_W-1:0] E_HEX_DIGIT = 4'd2;
  localparam logic [ERR_W-1:0] E_FRAC_DIGIT = 4'd3;
  localparam logic [ERR_W-1:0] E_EXP_START = 4'd4;
  localparam logic [ERR_W-1:0] E_EXP_DIGIT = 4'd5;
  localparam logic [ERR_W-1:0] E_EMPTY_CHAR = 4'd6;
  localparam logic [ERR_W-1:0] E_UNTERM_CHAR = 4'd7;
  localparam logic [ERR_W-1:0] E_NO_QUOTE = 4'd8;
  localparam logic [ERR_W-1:0] E_UNTERM_STR = 4'd9;
  localparam logic [ERR_W-1:0] E_LONE_AMP = 4'd10;
  localparam logic [ERR_W-1:0] E_LONE_BAR = 4'd11;

  localparam logic [VAL_W-1:0] VAL_MAX = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_ZERO, S_HEX0, S_HEX, S_OCT, S_POINT, S_FRAC, S_EXP,
    S_EXPSIGN, S_EXPDIG, S_IDENT, S_CHAR0, S_CHARCLOSE, S_STR, S_SLASH,
    S_COMMENT, S_BANG, S_EQ, S_LT, S_GT, S_AMP, S_BAR, S_CHARESC, S_STRESC,
    S_HALT
  } lex_state_t;

  // One result word, fields in output order.
  typedef struct packed {
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [REP_W-1:0]  start;
    logic [VAL_W-1:0]  value;
    logic [LINE_W-1:0] line;
    logic [ERR_W-1:0]  err;
    logic [KIND_W-1:0] kind;
  } token_t;

  // Keyword lookup over the six-byte name buffer; 0 means plain identifier.
  function automatic logic [KIND_W-1:0] word_kind(input logic [47:0] buf_in,
                                                  input logic [LEN_W-1:0] n);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if (n == 16'd5 && buf_in[39:0] == 40'h6B_61_65_72_62) k = K_BREAK;
    else if (n == 16'd4 && buf_in[31:0] == 32'h72_61_68_63) k = K_CHAR;
    else if (n == 16'd6 && buf_in == 48'h65_6C_62_75_6F_64) k = K_DOUBLE;
    else if (n == 16'd4 && buf_in[31:0] == 32'h65_73_6C_65) k = K_ELSE;
    else if (n == 16'd3 && buf_in[23:0] == 24'h72_6F_66) k = K_FOR;
    else if (n == 16'd2 && buf_in[15:0] == 16'h66_69) k = K_IF;
    else if (n == 16'd3 && buf_in[23:0] == 24'h74_6E_69) k = K_INT;
    else if (n == 16'd6 && buf_in == 48'h6E_72_75_74_65_72) k = K_RETURN;
    else if (n == 16'd6 && buf_in == 48'h74_63_75_72_74_73) k = K_STRUCT;
    else if (n == 16'd4 && buf_in[31:0] == 32'h64_69_6F_76) k = K_VOID;
    else if (n == 16'd5 && buf_in[39:0] == 40'h65_6C_69_68_77) k = K_WHILE;
    return k;
  endfunction

endpackage

// File: sv/csl_core.sv
// Lexer automaton: takes one byte per accepted word and produces up to two
// result words in one pass. Depends on csl_pkg.
module csl_core import csl_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] c,
  output logic [1:0] n_res,
  output token_t     res0,
  output token_t     res1
);

  lex_state_t               state, state_next;
  logic [LINE_W-1:0]        line_count, line_next;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] tstart, tstart_next;
  logic [47:0]              ibuf, ibuf_next;
  logic [LEN_W-1:0]         lcount, lcount_next;
  logic [VAL_W-1:0]         acc, acc_next;
  logic [7:0]               chv, chv_next;

  // Byte classes.
  logic is_dig, is_oct, is_alpha, is_xdig, is_exp, is_word;
  logic [3:0] xv;
  assign is_dig   = c >= 8'h30 && c <= 8'h39;
  assign is_oct   = c >= 8'h30 && c <= 8'h37;
  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_xdig  = is_dig || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  assign is_exp   = c == 8'h65 || c == 8'h45;
  assign is_word  = is_alpha || is_dig || c == 8'h5F;
  assign xv = is_dig ? c[3:0] : 4'(c[3:0] + 4'd9);

  // Saturating digit accumulation; the base is a power of two or ten.
  logic [2:0]  base_sel;
  logic [34:0] acc_x;
  logic [VAL_W-1:0] acc_sat;
  always_comb begin
    unique case (base_sel)
      3'd0:    acc_x = {acc, 3'b000} + {acc, 1'b0} + 35'(xv);
      3'd1:    acc_x = {1'b0, acc, 3'b000} + 35'(xv);
      default: acc_x = {acc, 4'b0000} + 35'(xv);
    endcase
    acc_sat = (acc_x > 35'(VAL_MAX)) ? VAL_MAX : acc_x[VAL_W-1:0];
  end
  assign base_sel = (state == S_DEC) ? 3'd0 :
                    (state == S_HEX0 || state == S_HEX) ? 3'd2 : 3'd1;

  logic [LEN_W-1:0] grown;
  assign grown = (lcount == 16'hFFFF) ? lcount : 16'(lcount + 16'd1);
  logic [LINE_W-1:0] line_inc;
  assign line_inc = (line_count == 24'hFFFFFF) ? line_count : 24'(line_count + 24'd1);

  logic [REP_W-1:0] pos_r, ts_r;
  assign pos_r = REP_W'(pos);
  assign ts_r  = REP_W'(tstart);

  // First phase: the current state sees the byte and may hand it back.
  token_t t_a;
  logic   emit_a, again, nl_a;
  lex_state_t st_a;
  logic [47:0] ibuf_a;
  logic [LEN_W-1:0] lc_a;
  logic [VAL_W-1:0] acc_a;
  logic [7:0] chv_a;

  function automatic token_t tok(input logic [KIND_W-1:0] k, input logic [ERR_W-1:0] e,
                                 input logic [VAL_W-1:0] v, input logic [REP_W-1:0] s,
                                 input logic [LEN_W-1:0] l);
    token_t t;
    t.kind = k; t.err = e; t.value = v; t.start = s; t.len = l;
    t.line = '0; t.last = 1'b0;
    return t;
  endfunction

  always_comb begin
    t_a = '0; emit_a = 1'b0; again = 1'b0; nl_a = 1'b0;
    st_a = state; ibuf_a = ibuf; lc_a = lcount; acc_a = acc; chv_a = chv;
    unique case (state)
      S_IDLE: again = 1'b1;
      S_DEC: begin
        if (is_dig) begin acc_a = acc_sat; lc_a = grown; end
        else if (c == 8'h2E) begin lc_a = grown; st_a = S_POINT; end
        else if (is_exp) begin lc_a = grown; st_a = S_EXP; end
        else begin emit_a = 1; t_a = tok(K_CT_INT, E_NONE, acc, ts_r, lcount); again = 1; end
      end
      S_ZERO: begin
        if (c == 8'h78 || c == 8'h58) begin lc_a = grown; st_a = S_HEX0; end
        else if (is_oct) begin acc_a = acc_sat; lc_a = grown; st_a = S_OCT; end
        else if (c == 8'h2E) begin lc_a = grown; st_a = S_POINT; end
        else if (is_exp) begin lc_a = grown; st_a = S_EXP; end
        else begin emit_a = 1; t_a = tok(K_CT_INT, E_NONE, '0, ts_r, lcount); again = 1; end
      end
      S_HEX0: begin
        if (is_xdig) begin acc_a = acc_sat; lc_a = grown; st_a = S_HEX; end
        else begin emit_a = 1; t_a = tok(K_END, E_HEX_DIGIT, '0, pos_r, '0); st_a = S_HALT; end
      end
      S_HEX, S_OCT: begin
        if (state == S_HEX ? is_xdig : is_oct) begin acc_a = acc_sat; lc_a = grown; end
        else begin emit_a = 1; t_a = tok(K_CT_INT, E_NONE, acc, ts_r, lcount); again = 1; end
      end
      S_POINT: begin
        if (is_dig) begin lc_a = grown; st_a = S_FRAC; end
        else begin emit_a = 1; t_a = tok(K_END, E_FRAC_DIGIT, '0, pos_r, '0); st_a = S_HALT; end
      end
      S_FRAC: begin
        if (is_dig) lc_a = grown;
        else if (is_exp) begin lc_a = grown; st_a = S_EXP; end
        else begin emit_a = 1; t_a = tok(K_CT_REAL, E_NONE, '0, ts_r, lcount); again = 1; end
      end
      S_EXP: begin
        if (c == 8'h2B || c == 8'h2D) begin lc_a = grown; st_a = S_EXPSIGN; end
        else if (is_dig) begin lc_a = grown; st_a = S_EXPDIG; end
        else begin emit_a = 1; t_a = tok(K_END, E_EXP_START, '0, pos_r, '0); st_a = S_HALT; end
      end
      S_EXPSIGN: begin
        if (is_dig) begin lc_a = grown; st_a = S_EXPDIG; end
        else begin emit_a = 1; t_a = tok(K_END, E_EXP_DIGIT, '0, pos_r, '0); st_a = S_HALT; end
      end
      S_EXPDIG: begin
        if (is_dig) lc_a = grown;
        else begin emit_a = 1; t_a = tok(K_CT_REAL, E_NONE, '0, ts_r, lcount); again = 1; end
      end
      S_IDENT: begin
        if (is_word) begin
          if (lcount < 16'd6) ibuf_a = ibuf | (48'(c) << {lcount[2:0], 3'b000});
          lc_a = grown;
        end else begin
          emit_a = 1; t_a = tok(word_kind(ibuf, lcount), E_NONE, '0, ts_r, lcount); again = 1;
        end
      end
      S_CHAR0: begin
        if (c == 8'h27) begin emit_a = 1; t_a = tok(K_END, E_EMPTY_CHAR, '0, pos_r, '0); st_a = S_HALT; end
        else if (c == 8'h00) begin emit_a = 1; t_a = tok(K_END, E_UNTERM_CHAR, '0, pos_r, '0); st_a = S_HALT; end
        else if (c == 8'h5C) begin lc_a = grown; st_a = S_CHARESC; end
        else begin nl_a = c == 8'h0A; chv_a = c; lc_a = grown; st_a = S_CHARCLOSE; end
      end
      S_CHARESC: begin
        if (c == 8'h00) begin emit_a = 1; t_a = tok(K_END, E_UNTERM_CHAR, '0, pos_r, '0); st_a = S_HALT; end
        else begin
          nl_a = c == 8'h0A;
          unique case (c)
            8'h6E:   chv_a = 8'd10;
            8'h74:   chv_a = 8'd9;
            8'h72:   chv_a = 8'd13;
            8'h30:   chv_a = 8'd0;
            default: chv_a = c;
          endcase
          lc_a = grown; st_a = S_CHARCLOSE;
        end
      end
      S_CHARCLOSE: begin
        if (c == 8'h27) begin emit_a = 1; t_a = tok(K_CT_CHAR, E_NONE, VAL_W'(chv), ts_r, grown); st_a = S_IDLE; end
        else begin emit_a = 1; t_a = tok(K_END, E_NO_QUOTE, '0, pos_r, '0); st_a = S_HALT; end
      end
      S_STR: begin
        if (c == 8'h22) begin emit_a = 1; t_a = tok(K_CT_STRING, E_NONE, '0, ts_r, grown); st_a = S_IDLE; end
        else if (c == 8'h00) begin emit_a = 1; t_a = tok(K_END, E_UNTERM_STR, '0, pos_r, '0); st_a = S_HALT; end
        else begin
          if (c == 8'h5C) st_a = S_STRESC;
          nl_a = c == 8'h0A; lc_a = grown;
        end
      end
      S_STRESC: begin
        if (c == 8'h00) begin emit_a = 1; t_a = tok(K_END, E_UNTERM_STR, '0, pos_r, '0); st_a = S_HALT; end
        else begin nl_a = c == 8'h0A; lc_a = grown; st_a = S_STR; end
      end
      S_SLASH: begin
        if (c == 8'h2F) st_a = S_COMMENT;
        else begin emit_a = 1; t_a = tok(K_DIV, E_NONE, '0, ts_r, lcount); again = 1; end
      end
      S_COMMENT: again = c == 8'h0A || c == 8'h0D || c == 8'h00;
      S_BANG, S_EQ, S_LT, S_GT: begin
        emit_a = 1;
        if (c == 8'h3D) begin
          st_a = S_IDLE;
          unique case (state)
            S_BANG:  t_a = tok(K_NOTEQ, E_NONE, '0, ts_r, grown);
            S_EQ:    t_a = tok(K_EQUAL, E_NONE, '0, ts_r, grown);
            S_LT:    t_a = tok(K_LESSEQ, E_NONE, '0, ts_r, grown);
            default: t_a = tok(K_GREATEREQ, E_NONE, '0, ts_r, grown);
          endcase
        end else begin
          again = 1;
          unique case (state)
            S_BANG:  t_a = tok(K_NOT, E_NONE, '0, ts_r, lcount);
            S_EQ:    t_a = tok(K_ASSIGN, E_NONE, '0, ts_r, lcount);
            S_LT:    t_a = tok(K_LESS, E_NONE, '0, ts_r, lcount);
            default: t_a = tok(K_GREATER, E_NONE, '0, ts_r, lcount);
          endcase
        end
      end
      S_AMP: begin
        emit_a = 1;
        if (c == 8'h26) begin t_a = tok(K_AND, E_NONE, '0, ts_r, grown); st_a = S_IDLE; end
        else begin t_a = tok(K_END, E_LONE_AMP, '0, pos_r, '0); st_a = S_HALT; end
      end
      S_BAR: begin
        emit_a = 1;
        if (c == 8'h7C) begin t_a = tok(K_OR, E_NONE, '0, ts_r, grown); st_a = S_IDLE; end
        else begin t_a = tok(K_END, E_LONE_BAR, '0, pos_r, '0); st_a = S_HALT; end
      end
      default: st_a = S_HALT;
    endcase
  end

  // Second phase: the byte starts a new token from the idle state.
  token_t t_b;
  logic   emit_b, nl_b;
  lex_state_t st_b;
  logic [KIND_W-1:0] punct;
  always_comb begin
    unique case (c)
      8'h2C: punct = K_COMMA;   8'h3B: punct = K_SEMI;
      8'h28: punct = K_LPAR;    8'h29: punct = K_RPAR;
      8'h5B: punct = K_LBRACK;  8'h5D: punct = K_RBRACK;
      8'h7B: punct = K_LACC;    8'h7D: punct = K_RACC;
      8'h2B: punct = K_ADD;     8'h2D: punct = K_SUB;
      8'h2A: punct = K_MUL;     8'h2E: punct = K_DOT;
      default: punct = K_END;
    endcase
  end

  logic begins;
  always_comb begin
    t_b = '0; emit_b = 1'b0; nl_b = 1'b0; st_b = S_IDLE; begins = 1'b1;
    priority if (c == 8'h20 || c == 8'h0D || c == 8'h09) begins = 1'b0;
    else if (c == 8'h0A) begin begins = 1'b0; nl_b = 1'b1; end
    else if (c == 8'h00) begin
      begins = 1'b0; emit_b = 1; t_b = tok(K_END, E_NONE, '0, pos_r, '0); st_b = S_HALT;
    end
    else if (c == 8'h30) st_b = S_ZERO;
    else if (c == 8'h27) st_b = S_CHAR0;
    else if (c == 8'h22) st_b = S_STR;
    else if (c == 8'h2F) st_b = S_SLASH;
    else if (c == 8'h21) st_b = S_BANG;
    else if (c == 8'h3D) st_b = S_EQ;
    else if (c == 8'h3C) st_b = S_LT;
    else if (c == 8'h3E) st_b = S_GT;
    else if (c == 8'h26) st_b = S_AMP;
    else if (c == 8'h7C) st_b = S_BAR;
    else if (punct != K_END) begin emit_b = 1; t_b = tok(punct, E_NONE, '0, pos_r, 16'd1); end
    else if (is_dig) st_b = S_DEC;
    else if (is_alpha || c == 8'h5F) st_b = S_IDENT;
    else begin
      begins = 1'b0; emit_b = 1; t_b = tok(K_END, E_BAD_CHAR, '0, pos_r, '0); st_b = S_HALT;
    end
  end

  // Merge the phases; line number is taken before any newline of this byte.
  logic [LINE_W-1:0] line_a;
  always_comb begin
    line_a = nl_a ? line_inc : line_count;
    state_next = st_a; tstart_next = tstart; ibuf_next = ibuf_a;
    lcount_next = lc_a; acc_next = acc_a; chv_next = chv; line_next = line_a;
    res0 = t_a; res1 = t_b;
    res0.line = line_count; res1.line = line_count;
    n_res = {1'b0, emit_a};
    if (!again) chv_next = chv_a;
    if (again) begin
      state_next = st_b;
      if (nl_b) line_next = line_inc;
      if (begins) begin
        tstart_next = pos; lcount_next = 16'd1; acc_next = '0;
        if (st_b == S_DEC) acc_next = VAL_W'(c[3:0]);
        if (st_b == S_IDENT) ibuf_next = 48'(c);
      end
      if (emit_a && emit_b) n_res = 2'd2;
      else if (emit_b) begin n_res = 2'd1; res0 = t_b; res0.line = line_count; end
    end else begin
      res0.line = line_count;
    end
    if (n_res == 2'd2) res1.last = 1'b1;
    else res0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; line_count <= 24'd1; pos <= '0; tstart <= '0;
      ibuf <= '0; lcount <= '0; acc <= '0; chv <= '0;
    end else if (step) begin
      if (state == S_HALT) begin
        state <= S_HALT;
      end else begin
        state <= state_next; line_count <= line_next;
        pos <= POSITION_BITS'(pos + 1'b1);
        tstart <= tstart_next; ibuf <= ibuf_next; lcount <= lcount_next;
        acc <= acc_next; chv <= chv_next;
      end
    end
  end

  // Checks on the automaton.
  a_halt_stays: assert property (@(posedge clk) disable iff (rst)
    state == S_HALT |=> state == S_HALT) else $error("halt left");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (n_res != 2'd0 && res0.err != E_NONE) |-> res0.kind == K_END)
    else $error("error without end kind");
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    acc <= VAL_MAX) else $error("accumulator range");

endmodule

// File: sv/csl_out.sv
// Output stage: holds up to two result words and presents them one by one,
// taking new words whenever it can drain. Depends on csl_pkg.
module csl_out import csl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] n_in,
  input  logic       load,
  input  token_t     w0,
  input  token_t     w1,
  output logic       busy,
  output logic       tvalid,
  input  logic       tready,
  output token_t     head
);

  token_t slot0, slot1;
  logic [1:0] cnt;
  logic take;

  assign tvalid = cnt != 2'd0;
  assign head   = slot0;
  assign take   = tvalid && tready;
  // Space for a new pair only once the held words drain this cycle.
  assign busy   = (cnt == 2'd2) || (cnt == 2'd1 && !tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (load && n_in != 2'd0) begin
        slot0 <= w0; slot1 <= w1; cnt <= n_in;
      end else if (take) begin
        slot0 <= slot1; cnt <= 2'(cnt - 2'd1);
      end
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("count range");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (load && n_in != 2'd0) |-> (cnt == 2'd0 || (cnt == 2'd1 && tready)))
    else $error("overwrite");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (tvalid && cnt == 2'd1) |-> head.last) else $error("last mark");

endmodule

// File: sv/c_subset_lexer.sv
// C subset lexer top level: byte stream in, token stream out.
// An accepted byte's first token word is registered and shown the next cycle.
// One byte per cycle while the output is ready; a byte giving two tokens
// holds the input while the second word drains from the output stage.
// Reset (rst, synchronous) returns to line 1, offset 0 and no held words.
module c_subset_lexer import csl_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // source_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // token_kind, error_code, line_number,
                                  // int_value, lexeme_start, lexeme_length
  output logic         m_tlast    // last_of_run
);

  logic [1:0] n_res;
  token_t     r0, r1, head;
  logic       busy, step;

  assign s_tready = !busy;
  assign step     = s_tvalid && s_tready;

  csl_core #(.POSITION_BITS(POSITION_BITS)) u_core (
    .clk(clk), .rst(rst), .step(step), .c(s_tdata),
    .n_res(n_res), .res0(r0), .res1(r1)
  );

  csl_out u_out (
    .clk(clk), .rst(rst), .n_in(n_res), .load(step), .w0(r0), .w1(r1),
    .busy(busy), .tvalid(m_tvalid), .tready(m_tready), .head(head)
  );

  // Result word packed from the lowest field up.
  assign m_tdata = {7'b0, head.len, head.start, head.value, head.line, head.err, head.kind};
  assign m_tlast = head.last;

endmodule
